>>> rtl/core/dasp_pkg.sv
`default_nettype none

package dasp_pkg;

   // Bits of value carried by one ULEB128 byte.
   localparam int unsigned ULEB_PAYLOAD_BITS = 7;

   // Shift count after a byte, and the value at which it saturates.
   localparam logic [6:0] ULEB_STEP      = 7'd7;
   localparam logic [6:0] ULEB_SHIFT_MAX = 7'd70;

   // Result kinds.
   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_PAIR   = 1'b1;

   // One classified input byte as it travels from the front part to the back part.
   typedef struct packed {
      logic [ULEB_PAYLOAD_BITS-1:0] payload;
      logic                         more;
      logic [7:0]                   data_byte;
      logic                         final_byte;
   } dasp_byte_type;

   // One result word, without the offset field whose width is a parameter.
   typedef struct packed {
      logic        kind;
      logic [63:0] decl_code;
      logic [63:0] decl_tag;
      logic [7:0]  children_flag;
      logic [63:0] pair_name;
      logic [63:0] pair_form;
      logic        end_of_decl;
      logic        truncated;
   } dasp_result_type;

endpackage

`default_nettype wire

>>> rtl/core/dasp_fifo.sv
`default_nettype none

module dasp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output logic      [WIDTH-1:0] rd_data,
   output logic                  empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   // Status and read port.
   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   // Pointer and count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/dasp_front.sv
`default_nettype none

module dasp_front #(
   parameter int OFFSET_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [7:0]             data_byte,
   input  wire logic                   final_byte,
   input  wire logic                   push,
   input  wire logic                   queue_full,
   output logic                        item_write,
   output dasp_pkg::dasp_byte_type     item,
   output logic      [OFFSET_BITS-1:0] item_pos
);

   import dasp_pkg::*;

   logic [OFFSET_BITS-1:0] pos_ff, pos_in;

   // A word is taken whenever push is high and the queue toward the back part has room.
   assign item_write = push && !queue_full;

   // Split the byte into its ULEB128 payload and continuation flag.
   always_comb begin
      item.payload    = data_byte[ULEB_PAYLOAD_BITS-1:0];
      item.more       = data_byte[7];
      item.data_byte  = data_byte;
      item.final_byte = final_byte;
   end
   assign item_pos = pos_ff;

   // Byte offset within the buffer; it wraps at the offset width and
   // restarts after the final byte.
   always_comb begin
      pos_in = pos_ff;
      if (item_write) begin
         pos_in = final_byte ? '0 : pos_ff + OFFSET_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/dasp_back.sv
`default_nettype none

module dasp_back #(
   parameter int OFFSET_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     item_valid,
   input  wire dasp_pkg::dasp_byte_type  item,
   input  wire logic   [OFFSET_BITS-1:0] item_pos,
   output logic                          item_take,
   input  wire logic                     result_full,
   output logic                          result_write,
   output dasp_pkg::dasp_result_type     result,
   output logic        [OFFSET_BITS-1:0] result_offset
);

   import dasp_pkg::*;

   // Parser phases.
   localparam logic [2:0] PH_CODE  = 3'd0;
   localparam logic [2:0] PH_TAG   = 3'd1;
   localparam logic [2:0] PH_CHILD = 3'd2;
   localparam logic [2:0] PH_NAME  = 3'd3;
   localparam logic [2:0] PH_FORM  = 3'd4;

   logic [2:0]             phase_ff, phase_in;
   logic [63:0]            acc_ff, acc_in;
   logic [6:0]             shift_ff, shift_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [63:0]            code_ff, code_in;
   logic [63:0]            tag_ff, tag_in;
   logic [63:0]            name_ff, name_in;
   logic [7:0]             children_ff, children_in;

   logic [63:0] acc_take;
   logic [6:0]  shift_take;
   logic        done;
   logic        fin;
   logic        list_end;

   // The back part steps whenever a word is waiting and the result queue has room.
   assign item_take = item_valid && !result_full;
   assign done      = !item.more;
   assign fin       = item.final_byte;

   // One ULEB128 byte folded into the accumulator; bits beyond 64 are dropped.
   always_comb begin
      acc_take = acc_ff;
      if (!shift_ff[6]) begin
         acc_take = acc_ff | ({{(64 - ULEB_PAYLOAD_BITS){1'b0}}, item.payload}
                              << shift_ff[5:0]);
      end
      shift_take = (shift_ff > 7'd63) ? ULEB_SHIFT_MAX : shift_ff + ULEB_STEP;
   end

   assign list_end = (name_ff == 64'd0) || (acc_take == 64'd0);

   // Phase sequencer and result formation.
   always_comb begin
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      shift_in     = shift_ff;
      start_in     = start_ff;
      code_in      = code_ff;
      tag_in       = tag_ff;
      name_in      = name_ff;
      children_in  = children_ff;
      result_write = 1'b0;

      result.kind          = KIND_PAIR;
      result.decl_code     = code_ff;
      result.decl_tag      = tag_ff;
      result.children_flag = children_ff;
      result.pair_name     = name_ff;
      result.pair_form     = 64'd0;
      result.end_of_decl   = 1'b1;
      result.truncated     = 1'b1;
      result_offset        = start_ff;

      if (item_take) begin
         case (phase_ff)
            PH_CODE: begin
               // A code is begun only when another byte follows.
               if (!(shift_ff == 7'd0 && fin)) begin
                  if (shift_ff == 7'd0) begin
                     start_in = item_pos;
                  end
                  if (done) begin
                     if (acc_take != 64'd0) begin
                        code_in  = acc_take;
                        phase_in = PH_TAG;
                     end
                     acc_in   = 64'd0;
                     shift_in = 7'd0;
                  end else begin
                     acc_in   = acc_take;
                     shift_in = shift_take;
                  end
               end
            end
            PH_TAG: begin
               if (done) begin
                  tag_in   = acc_take;
                  acc_in   = 64'd0;
                  shift_in = 7'd0;
                  phase_in = PH_CHILD;
               end else begin
                  acc_in   = acc_take;
                  shift_in = shift_take;
               end
            end
            PH_CHILD: begin
               // The children byte completes the header.
               children_in          = item.data_byte;
               phase_in             = PH_NAME;
               result_write         = 1'b1;
               result.kind          = KIND_HEADER;
               result.children_flag = item.data_byte;
               result.pair_name     = 64'd0;
               result.end_of_decl   = 1'b0;
               result.truncated     = 1'b0;
            end
            PH_NAME: begin
               if (done) begin
                  name_in  = acc_take;
                  acc_in   = 64'd0;
                  shift_in = 7'd0;
                  phase_in = PH_FORM;
               end else begin
                  acc_in   = acc_take;
                  shift_in = shift_take;
               end
               // A pair cut off after or inside its name.
               result_write     = fin;
               result.pair_name = acc_take;
            end
            PH_FORM: begin
               result.pair_form = acc_take;
               if (done) begin
                  result_write       = 1'b1;
                  result.end_of_decl = list_end || fin;
                  result.truncated   = 1'b0;
                  acc_in             = 64'd0;
                  shift_in           = 7'd0;
                  phase_in           = list_end ? PH_CODE : PH_NAME;
               end else begin
                  acc_in       = acc_take;
                  shift_in     = shift_take;
                  result_write = fin;
               end
            end
            default: begin
               phase_in = PH_CODE;
            end
         endcase

         // The end of the buffer returns the parser to its reset state.
         if (fin) begin
            phase_in    = PH_CODE;
            acc_in      = 64'd0;
            shift_in    = 7'd0;
            start_in    = '0;
            code_in     = 64'd0;
            tag_in      = 64'd0;
            name_in     = 64'd0;
            children_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CODE;
         acc_ff   <= 64'd0;
         shift_ff <= 7'd0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         shift_ff <= shift_in;
      end
   end

   // Held declaration fields are always written before they are shown.
   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      code_ff     <= code_in;
      tag_ff      <= tag_in;
      name_ff     <= name_in;
      children_ff <= children_in;
   end

endmodule

`default_nettype wire

>>> rtl/core/dwarf_abbrev_stream_parser.sv
// Debug abbreviation section parser.
// Input channel: one section byte per word on req_data_byte, with
// req_final_byte set on the last byte of the buffer. A word is taken at a
// clock edge where req_push is high and req_full is low.
// Result channel: a queue view. While rsp_empty is low the oldest result is
// on the rsp_ ports; it is taken at an edge where rsp_pop is high.
// A header result follows each declaration's children byte, and one pair
// result follows each attribute name/form pair.
// Throughput: one byte per cycle while the result queue has room; the back
// part's ULEB128 accumulator and phase update close for each byte as it is taken.
// A result caused by a byte passes from the input queue through the back part
// into the result queue, whose oldest word is on the rsp_ ports to be popped.
// When the receiver stalls, the two-word result queue fills, the back part
// stops, the two-word input queue fills and req_full rises; nothing is lost.
// Reset clears both queues, the offset counter and the parser phase; the
// block is ready in the cycle after reset falls.
`default_nettype none

module dwarf_abbrev_stream_parser #(
   parameter int OFFSET_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [7:0]             req_data_byte,
   input  wire logic                   req_final_byte,
   input  wire logic                   req_push,
   output logic                        req_full,
   output logic                        rsp_kind,
   output logic      [63:0]            rsp_decl_code,
   output logic      [63:0]            rsp_decl_tag,
   output logic      [OFFSET_BITS-1:0] rsp_decl_offset,
   output logic      [7:0]             rsp_children_flag,
   output logic      [63:0]            rsp_pair_name,
   output logic      [63:0]            rsp_pair_form,
   output logic                        rsp_end_of_decl,
   output logic                        rsp_truncated,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop
);

   import dasp_pkg::*;

   localparam int QUEUE_DEPTH = 2;
   localparam int ITEM_BITS   = $bits(dasp_byte_type) + OFFSET_BITS;
   localparam int RESULT_BITS = $bits(dasp_result_type) + OFFSET_BITS;

   logic                   item_write;
   dasp_byte_type          item_wr;
   logic [OFFSET_BITS-1:0] pos_wr;
   logic [ITEM_BITS-1:0]   item_rd_bits;
   logic                   item_empty;
   logic                   item_take;
   dasp_byte_type          item_rd;
   logic [OFFSET_BITS-1:0] pos_rd;

   logic                   result_write;
   logic                   result_full;
   dasp_result_type        result_wr;
   logic [OFFSET_BITS-1:0] offset_wr;
   logic [RESULT_BITS-1:0] result_rd_bits;
   dasp_result_type        result_rd;

   // Front part: offset tracking and byte classification.
   dasp_front #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .data_byte  (req_data_byte),
      .final_byte (req_final_byte),
      .push       (req_push),
      .queue_full (req_full),
      .item_write (item_write),
      .item       (item_wr),
      .item_pos   (pos_wr)
   );

   // Queue between the front and back parts.
   dasp_fifo #(
      .WIDTH (ITEM_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (item_write),
      .wr_data ({pos_wr, item_wr}),
      .full    (req_full),
      .rd_en   (item_take),
      .rd_data (item_rd_bits),
      .empty   (item_empty)
   );

   assign item_rd = item_rd_bits[$bits(dasp_byte_type)-1:0];
   assign pos_rd  = item_rd_bits[ITEM_BITS-1:$bits(dasp_byte_type)];

   // Back part: ULEB128 decoding and declaration parsing.
   dasp_back #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (!item_empty),
      .item          (item_rd),
      .item_pos      (pos_rd),
      .item_take     (item_take),
      .result_full   (result_full),
      .result_write  (result_write),
      .result        (result_wr),
      .result_offset (offset_wr)
   );

   // Result queue toward the receiver.
   dasp_fifo #(
      .WIDTH (RESULT_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (result_write),
      .wr_data ({offset_wr, result_wr}),
      .full    (result_full),
      .rd_en   (rsp_pop),
      .rd_data (result_rd_bits),
      .empty   (rsp_empty)
   );

   // Result fields onto the ports.
   assign result_rd         = result_rd_bits[$bits(dasp_result_type)-1:0];
   assign rsp_decl_offset   = result_rd_bits[RESULT_BITS-1:$bits(dasp_result_type)];
   assign rsp_kind          = result_rd.kind;
   assign rsp_decl_code     = result_rd.decl_code;
   assign rsp_decl_tag      = result_rd.decl_tag;
   assign rsp_children_flag = result_rd.children_flag;
   assign rsp_pair_name     = result_rd.pair_name;
   assign rsp_pair_form     = result_rd.pair_form;
   assign rsp_end_of_decl   = result_rd.end_of_decl;
   assign rsp_truncated     = result_rd.truncated;

endmodule

`default_nettype wire

>>> verif/tb_dwarf_abbrev_stream_parser.sv
`timescale 1ns / 1ps

module tb_dwarf_abbrev_stream_parser;
   import dasp_pkg::*;

   // Parser phases of the local prediction.
   typedef enum logic [2:0] {
      SCAN_CODE,
      SCAN_TAG,
      SCAN_CHILD,
      SCAN_NAME,
      SCAN_FORM
   } scan_phase_type;

   // One section byte waiting to be sent; hold makes the sender drain first.
   typedef struct packed {
      logic [7:0] data;
      logic       fin;
      logic       hold;
   } section_byte_type;

   // One expected result word.
   typedef struct packed {
      logic        kind;
      logic [63:0] code;
      logic [63:0] tag;
      logic [31:0] offset;
      logic [7:0]  children;
      logic [63:0] name;
      logic [63:0] form;
      logic        closes;
      logic        cut;
   } decl_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_final_byte = 1'b0;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        rsp_kind;
   logic [63:0] rsp_decl_code;
   logic [63:0] rsp_decl_tag;
   logic [31:0] rsp_decl_offset;
   logic [7:0]  rsp_children_flag;
   logic [63:0] rsp_pair_name;
   logic [63:0] rsp_pair_form;
   logic        rsp_end_of_decl;
   logic        rsp_truncated;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;

   section_byte_type section_q[$];
   logic [7:0]       draft_q[$];
   decl_result_type  pending_results[$];
   int               error_count = 0;

   // Idle bookkeeping for both sides.
   int send_gap = 0;
   int send_calm = 0;
   int pop_stall = 0;
   int pop_calm = 0;

   // State of the local prediction.
   scan_phase_type scan_phase = SCAN_CODE;
   logic [63:0] uleb_acc = '0;
   logic [6:0]  uleb_shift = '0;
   logic [31:0] byte_count = '0;
   logic [31:0] decl_start = '0;
   logic [63:0] cur_code = '0;
   logic [63:0] cur_tag = '0;
   logic [63:0] cur_name = '0;
   logic [7:0]  cur_children = '0;

   dwarf_abbrev_stream_parser #(
      .OFFSET_BITS(32)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_data_byte    (req_data_byte),
      .req_final_byte   (req_final_byte),
      .req_push         (req_push),
      .req_full         (req_full),
      .rsp_kind         (rsp_kind),
      .rsp_decl_code    (rsp_decl_code),
      .rsp_decl_tag     (rsp_decl_tag),
      .rsp_decl_offset  (rsp_decl_offset),
      .rsp_children_flag(rsp_children_flag),
      .rsp_pair_name    (rsp_pair_name),
      .rsp_pair_form    (rsp_pair_form),
      .rsp_end_of_decl  (rsp_end_of_decl),
      .rsp_truncated    (rsp_truncated),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Clear the decoder state, as happens after the final byte of a buffer.
   function automatic void scan_reset();
      scan_phase = SCAN_CODE;
      uleb_acc = '0;
      uleb_shift = '0;
      byte_count = '0;
      decl_start = '0;
      cur_code = '0;
      cur_tag = '0;
      cur_name = '0;
      cur_children = '0;
   endfunction

   function automatic void uleb_clear();
      uleb_acc = '0;
      uleb_shift = '0;
   endfunction

   // Add one ULEB128 byte; bits at weight 2^64 and above fall away.
   // Returns 1 when the value is complete.
   function automatic bit uleb_absorb(input logic [7:0] b);
      if (uleb_shift < 7'd64) uleb_acc |= 64'(b[6:0]) << uleb_shift;
      if (uleb_shift + ULEB_STEP > ULEB_SHIFT_MAX) uleb_shift = ULEB_SHIFT_MAX;
      else uleb_shift = uleb_shift + ULEB_STEP;
      return !b[7];
   endfunction

   function automatic decl_result_type make_result(input logic kind,
                                                   input logic [63:0] name, form,
                                                   input logic closes, cut);
      decl_result_type r;
      r.kind = kind;
      r.code = cur_code;
      r.tag = cur_tag;
      r.offset = decl_start;
      r.children = cur_children;
      r.name = name;
      r.form = form;
      r.closes = closes;
      r.cut = cut;
      return r;
   endfunction

   // Work out what one accepted byte produces and queue it.
   task automatic predict_byte(input logic [7:0] b, input logic fin);
      logic [31:0] pos;
      logic        closes;
      pos = byte_count;
      byte_count = pos + 32'd1;
      case (scan_phase)
         SCAN_CODE: begin
            // A code is never begun on the final byte.
            if (!(uleb_shift == 0 && fin)) begin
               if (uleb_shift == 0) decl_start = pos;
               if (uleb_absorb(b)) begin
                  // A zero code is padding and is skipped.
                  if (uleb_acc != 0) begin
                     cur_code = uleb_acc;
                     scan_phase = SCAN_TAG;
                  end
                  uleb_clear();
               end
            end
         end
         SCAN_TAG: begin
            if (uleb_absorb(b)) begin
               cur_tag = uleb_acc;
               uleb_clear();
               scan_phase = SCAN_CHILD;
            end
         end
         SCAN_CHILD: begin
            cur_children = b;
            pending_results.push_back(make_result(KIND_HEADER, '0, '0, 1'b0, 1'b0));
            scan_phase = SCAN_NAME;
         end
         SCAN_NAME: begin
            if (uleb_absorb(b)) begin
               cur_name = uleb_acc;
               uleb_clear();
               scan_phase = SCAN_FORM;
               if (fin)
                  pending_results.push_back(make_result(KIND_PAIR, cur_name, '0,
                                                        1'b1, 1'b1));
            end else if (fin) begin
               pending_results.push_back(make_result(KIND_PAIR, uleb_acc, '0,
                                                     1'b1, 1'b1));
            end
         end
         default: begin
            // Attribute form; either value being zero ends the list.
            if (uleb_absorb(b)) begin
               closes = (cur_name == 0) || (uleb_acc == 0);
               pending_results.push_back(make_result(KIND_PAIR, cur_name, uleb_acc,
                                                     closes || fin, 1'b0));
               uleb_clear();
               scan_phase = closes ? SCAN_CODE : SCAN_NAME;
            end else if (fin) begin
               pending_results.push_back(make_result(KIND_PAIR, cur_name, uleb_acc,
                                                     1'b1, 1'b1));
            end
         end
      endcase
      if (fin) scan_reset();
   endtask

   // Idle lengths: mostly none or short, a few long, and calm stretches.
   function automatic int draw_idle(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [63:0] random_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 64'($urandom_range(1, 127));
         4, 5: return 64'($urandom_range(128, 16384));
         6: return {$urandom, $urandom};
         7: return '1;
         8: return 64'($urandom_range(0, 3));
         default: return 64'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] nonzero_value();
      logic [63:0] v;
      v = random_value();
      return (v == 0) ? 64'd1 : v;
   endfunction

   // Extra continuation bytes for padded or overlong encodings.
   function automatic int pad_count();
      int r;
      r = $urandom_range(0, 19);
      if (r < 16) return 0;
      if (r < 18) return 1;
      if (r < 19) return 2;
      return $urandom_range(4, 6);
   endfunction

   // Append a ULEB128 value; bytes past the tenth carry random payload,
   // which the parser must drop.
   task automatic draft_uleb(input logic [63:0] v, input int pad);
      logic [63:0] rest;
      logic [7:0]  chunk;
      int          k;
      rest = v;
      k = 0;
      forever begin
         chunk = (k >= 10) ? 8'($urandom_range(0, 127)) : {1'b0, rest[6:0]};
         rest = rest >> 7;
         if (rest == 0 && pad == 0) begin
            draft_q.push_back(chunk);
            break;
         end
         if (rest == 0) pad--;
         draft_q.push_back(chunk | 8'h80);
         k++;
      end
   endtask

   // Move the draft buffer into the send queue, ending it at byte cut.
   task automatic commit_draft(input int cut, input bit hold);
      for (int i = 0; i <= cut; i++)
         section_q.push_back('{data: draft_q[i], fin: (i == cut), hold: (hold && i == 0)});
   endtask

   // One random buffer: mostly well-formed declarations, sometimes cut short,
   // sometimes plain noise.
   task automatic queue_buffer(input bit hold);
      int decls;
      int cut;
      draft_q.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 24)) draft_q.push_back(8'($urandom));
      end else begin
         decls = $urandom_range(1, 4);
         for (int d = 0; d < decls; d++) begin
            if ($urandom_range(0, 7) == 0) draft_uleb('0, $urandom_range(0, 1));
            draft_uleb(nonzero_value(), pad_count());
            draft_uleb(random_value(), pad_count());
            draft_q.push_back(8'($urandom));
            repeat ($urandom_range(0, 5)) begin
               draft_uleb(nonzero_value(), pad_count());
               draft_uleb(nonzero_value(), pad_count());
            end
            // The last declaration is sometimes left open at the buffer end.
            if (d < decls - 1 || $urandom_range(0, 3) != 0) begin
               case ($urandom_range(0, 2))
                  0: begin
                     draft_uleb('0, pad_count());
                     draft_uleb('0, pad_count());
                  end
                  1: begin
                     draft_uleb('0, pad_count());
                     draft_uleb(nonzero_value(), pad_count());
                  end
                  default: begin
                     draft_uleb(nonzero_value(), pad_count());
                     draft_uleb('0, pad_count());
                  end
               endcase
            end
         end
      end
      cut = draft_q.size() - 1;
      if ($urandom_range(0, 2) == 0) cut = $urandom_range(0, draft_q.size() - 1);
      commit_draft(cut, hold);
   endtask

   task automatic check_field(input string label, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      end
   endtask

   // Sender: offers queued bytes, predicts each accepted word, idles at random.
   always @(posedge clock) begin : drive_proc
      section_byte_type next_byte;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) predict_byte(req_data_byte, req_final_byte);
         if (!req_push || !req_full) begin
            if (send_gap > 0) begin
               send_gap--;
               req_push <= 1'b0;
            end else if (section_q.size() > 0 &&
                         !(section_q[0].hold && pending_results.size() > 0)) begin
               next_byte = section_q.pop_front();
               req_data_byte <= next_byte.data;
               req_final_byte <= next_byte.fin;
               req_push <= 1'b1;
               send_gap = draw_idle(send_calm);
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Receiver: takes result words with random stalls and checks each one.
   always @(posedge clock) begin : watch_proc
      decl_result_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_results.size() == 0) begin
               error_count++;
               $display("%0t: result word with nothing expected, actual kind %h code %h",
                        $time, rsp_kind, rsp_decl_code);
            end else begin
               want = pending_results.pop_front();
               check_field("kind", 64'(want.kind), 64'(rsp_kind));
               check_field("decl_code", want.code, rsp_decl_code);
               check_field("decl_tag", want.tag, rsp_decl_tag);
               check_field("decl_offset", 64'(want.offset), 64'(rsp_decl_offset));
               check_field("children_flag", 64'(want.children), 64'(rsp_children_flag));
               check_field("pair_name", want.name, rsp_pair_name);
               check_field("pair_form", want.form, rsp_pair_form);
               check_field("end_of_decl", 64'(want.closes), 64'(rsp_end_of_decl));
               check_field("truncated", 64'(want.cut), 64'(rsp_truncated));
            end
         end
         if (pop_stall > 0) begin
            pop_stall--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            pop_stall = draw_idle(pop_calm);
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin : stimulus_proc
      int buf_count;
      // A one-byte buffer, then a declaration cut before its children byte.
      draft_q = '{8'h05};
      commit_draft(draft_q.size() - 1, 1'b0);
      draft_q = '{8'h01, 8'h02};
      commit_draft(draft_q.size() - 1, 1'b0);
      // Skipped zero code, header, a pair, a zero form closing the list,
      // and a code that would begin on the final byte.
      draft_q = '{8'h00, 8'h01, 8'h11, 8'h01, 8'h03, 8'h08, 8'h05, 8'h00, 8'h01};
      commit_draft(draft_q.size() - 1, 1'b0);
      // Overlong all-ones code whose eleventh byte is dropped; children byte last.
      draft_q.delete();
      repeat (10) draft_q.push_back(8'hFF);
      draft_q.push_back(8'h7F);
      draft_q.push_back(8'h00);
      draft_q.push_back(8'hFF);
      commit_draft(draft_q.size() - 1, 1'b0);
      // Name cut mid-value, name ending on the final byte, form cut mid-value.
      draft_q = '{8'h01, 8'h01, 8'h00, 8'h85};
      commit_draft(draft_q.size() - 1, 1'b0);
      draft_q = '{8'h01, 8'h01, 8'h00, 8'h09};
      commit_draft(draft_q.size() - 1, 1'b0);
      draft_q = '{8'h01, 8'h01, 8'h00, 8'h09, 8'h82};
      commit_draft(draft_q.size() - 1, 1'b0);

      // Random buffers; two of them wait for the result queue to drain.
      buf_count = 0;
      while (section_q.size() < 2000) begin
         queue_buffer(buf_count == 40 || buf_count == 120);
         buf_count++;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (section_q.size() != 0 || req_push) @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0) begin
         $display("PASS dwarf_abbrev_stream_parser");
      end else begin
         $display("FAIL dwarf_abbrev_stream_parser");
      end
      $finish;
   end

   // Watchdog for a hung run.
   initial begin
      #15000000;
      $display("FAIL dwarf_abbrev_stream_parser");
      $finish;
   end

endmodule
